/* sv/tba_pkg.sv */
// Shared types and constants for the time bucket averager.
package tba_pkg;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_TIME      = 2'd0,
    REG_BUCKET_LENGTH   = 2'd1,
    REG_BUCKET_CAPACITY = 2'd2,
    REG_RAW_LIMIT       = 2'd3
  } cfg_reg_t;

  localparam logic [31:0] StartTimeReset      = 32'd0;
  localparam logic [31:0] BucketLengthReset   = 32'd60;
  localparam logic [15:0] BucketCapacityReset = 16'd64;
  localparam logic [15:0] RawLimitReset       = 16'd2000;

  localparam int unsigned NumLanes = 5;
  localparam int unsigned LaneW    = $clog2(NumLanes);

  typedef enum logic [LaneW-1:0] {
    LANE_TEMP     = 3'd0,
    LANE_HUMIDITY = 3'd1,
    LANE_ECO2     = 3'd2,
    LANE_TVOC     = 3'd3,
    LANE_AIR      = 3'd4
  } lane_t;

  typedef struct packed {
    logic [31:0]        stamp;
    logic signed [15:0] temp_centi;
    logic [15:0]        humidity_centi;
    logic [15:0]        eco2_ppm;
    logic [15:0]        tvoc_ppb;
    logic [7:0]         air_index;
    logic               end_of_stream;
  } item_t;

  typedef struct packed {
    logic [31:0]        bucket_time;
    logic [15:0]        sample_count;
    logic signed [15:0] temp_mean;
    logic [15:0]        humidity_mean;
    logic [15:0]        eco2_mean;
    logic [15:0]        tvoc_mean;
    logic [7:0]         air_index_mean;
    logic               final_bucket;
  } result_t;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] bucket_length;
    logic [15:0] bucket_capacity;
    logic [15:0] raw_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ROUND,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_PUSH,
    S_ACC,
    S_EOS,
    S_CLEAR
  } back_state_t;

endpackage

/* sv/tba_fifo.sv */
// Small first-in first-out queue of words.
module tba_fifo #(
  parameter type word_t = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  word_t wdata,
  output logic  full,
  input  logic  rd,
  output word_t rdata,
  output logic  empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  word_t         mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* sv/tba_div.sv */
// Radix-2 restoring divider, 32 by 32 bits, one quotient bit per cycle.
module tba_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] dsr;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign rem_sh = {rem, quo[31]};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* sv/tba_back.sv */
// Back end: bucket rounding and accumulation per record, mean computation per closed bucket.
module tba_back (
  input  logic            clk,
  input  logic            rst,
  input  tba_pkg::cfg_t   cfg,
  input  logic            in_empty,
  input  tba_pkg::item_t  in_word,
  output logic            in_pop,
  input  logic            out_full,
  output logic            out_push,
  output tba_pkg::result_t out_word
);

  import tba_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  item_t              cur;
  logic               passed_start;
  logic [15:0]        raw_taken;
  logic [15:0]        buckets_sent;
  logic               bucket_open;
  logic [31:0]        open_bucket_time;
  logic [15:0]        open_count;
  logic signed [32:0] temp_sum;
  logic [31:0]        humidity_sum;
  logic [31:0]        eco2_sum;
  logic [31:0]        tvoc_sum;
  logic [23:0]        air_index_sum;
  logic [31:0]        bt;
  logic               emit_end;
  lane_t              lane;
  logic               tneg;
  result_t            res;

  logic               enabled;
  logic               passed_now;
  logic               go;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_quo;
  logic [31:0]        div_rem;
  logic [31:0]        div_a;
  logic [31:0]        div_b;
  logic [31:0]        bt_new;
  logic               change;
  logic [32:0]        temp_abs;
  logic [15:0]        sent_inc;
  logic [31:0]        tq;

  assign enabled    = (cfg.bucket_length != '0) && (cfg.bucket_capacity != '0);
  assign passed_now = passed_start || (enabled && (cur.stamp >= cfg.start_time));
  assign go         = enabled && passed_now && (raw_taken < cfg.raw_limit) &&
                      (buckets_sent < cfg.bucket_capacity);
  assign bt_new     = cur.stamp - div_rem;
  assign change     = bucket_open && (bt_new != open_bucket_time);
  assign temp_abs   = temp_sum[32] ? -temp_sum : temp_sum;
  assign sent_inc   = buckets_sent + 16'd1;
  assign tq         = tneg ? -div_quo : div_quo;

  always_comb begin
    div_a = cur.stamp;
    div_b = cfg.bucket_length;
    if (state == S_MEAN_GO) begin
      div_b = {16'd0, open_count};
      case (lane)
        LANE_TEMP:     div_a = temp_abs[31:0];
        LANE_HUMIDITY: div_a = humidity_sum;
        LANE_ECO2:     div_a = eco2_sum;
        LANE_TVOC:     div_a = tvoc_sum;
        LANE_AIR:      div_a = {8'd0, air_index_sum};
        default:       div_a = humidity_sum;
      endcase
    end
  end

  tba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (!in_empty) state_next = S_CHECK;
      S_CHECK:     state_next = go ? S_ROUND : S_EOS;
      S_ROUND:     if (div_done) state_next = change ? S_MEAN_GO : S_ACC;
      S_MEAN_GO:   state_next = S_MEAN_WAIT;
      S_MEAN_WAIT: begin
        if (div_done) state_next = (lane == LANE_AIR) ? S_PUSH : S_MEAN_GO;
      end
      S_PUSH:      if (!out_full) state_next = emit_end ? S_CLEAR : S_ACC;
      S_ACC:       state_next = S_EOS;
      S_EOS: begin
        if (!cur.end_of_stream) begin
          state_next = S_IDLE;
        end else if (enabled && (buckets_sent < cfg.bucket_capacity) && bucket_open) begin
          state_next = S_MEAN_GO;
        end else begin
          state_next = S_CLEAR;
        end
      end
      S_CLEAR:     state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_pop    = (state == S_IDLE) && !in_empty;
    out_push  = (state == S_PUSH) && !out_full;
    div_start = ((state == S_CHECK) && go) || (state == S_MEAN_GO);
    out_word  = res;
    out_word.final_bucket = emit_end || (sent_inc >= cfg.bucket_capacity);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      cur <= in_word;
    end
    if ((state == S_ROUND) && div_done) begin
      bt       <= bt_new;
      emit_end <= 1'b0;
      lane     <= LANE_TEMP;
    end
    if ((state == S_EOS) && (state_next == S_MEAN_GO)) begin
      emit_end <= 1'b1;
      lane     <= LANE_TEMP;
    end
    if ((state == S_MEAN_GO) && (lane == LANE_TEMP)) begin
      tneg                 <= temp_sum[32];
      res.bucket_time      <= open_bucket_time;
      res.sample_count     <= open_count;
    end
    if ((state == S_MEAN_WAIT) && div_done) begin
      lane <= lane_t'(lane + LaneW'(1));
      case (lane)
        LANE_TEMP:     res.temp_mean      <= tq[15:0];
        LANE_HUMIDITY: res.humidity_mean  <= div_quo[15:0];
        LANE_ECO2:     res.eco2_mean      <= div_quo[15:0];
        LANE_TVOC:     res.tvoc_mean      <= div_quo[15:0];
        LANE_AIR:      res.air_index_mean <= div_quo[7:0];
        default:       res.humidity_mean  <= div_quo[15:0];
      endcase
    end
    res.final_bucket <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst || (state == S_CLEAR)) begin
      passed_start     <= 1'b0;
      raw_taken        <= '0;
      buckets_sent     <= '0;
      bucket_open      <= 1'b0;
      open_bucket_time <= '0;
      open_count       <= '0;
      temp_sum         <= '0;
      humidity_sum     <= '0;
      eco2_sum         <= '0;
      tvoc_sum         <= '0;
      air_index_sum    <= '0;
    end else begin
      if (state == S_CHECK) begin
        passed_start <= passed_now;
      end
      if (out_push) begin
        buckets_sent  <= sent_inc;
        bucket_open   <= 1'b0;
        open_count    <= '0;
        temp_sum      <= '0;
        humidity_sum  <= '0;
        eco2_sum      <= '0;
        tvoc_sum      <= '0;
        air_index_sum <= '0;
      end
      if ((state == S_ACC) && (buckets_sent < cfg.bucket_capacity)) begin
        if (!bucket_open) begin
          bucket_open      <= 1'b1;
          open_bucket_time <= bt;
        end
        open_count    <= open_count + 16'd1;
        temp_sum      <= temp_sum + 33'(cur.temp_centi);
        humidity_sum  <= humidity_sum + {16'd0, cur.humidity_centi};
        eco2_sum      <= eco2_sum + {16'd0, cur.eco2_ppm};
        tvoc_sum      <= tvoc_sum + {16'd0, cur.tvoc_ppb};
        air_index_sum <= air_index_sum + {16'd0, cur.air_index};
        raw_taken     <= raw_taken + 16'd1;
      end
    end
  end

endmodule

/* sv/time_bucket_averager.sv */
// Time bucket averager: tumbling-window means over a stream of sensor records.
//
// Input side is a queue: a record word is taken when push is high and full low.
// Result side is a queue: the oldest bucket word sits on result while empty is
// low and leaves when pop is high. Registers are written over the cfg channel
// (cfg_ready is always high); the user must write them only while no record is
// in flight, as the block itself does not enforce it. A record waits in a short
// input queue, then the back end rounds its stamp down to the bucket length with
// a serial divider. Closing a bucket runs five more divides for the means plus
// a push. Results are pushed into the output queue from the push state after the
// last divide, once the output queue has room.
// When the receiver stalls, results collect in the output queue; once it is
// full the back end waits, the input queue fills and full rises.
// Reset empties both queues, clears the run state and loads the register
// defaults: start 0, bucket length 60, capacity 64, raw limit 2000.
module time_bucket_averager #(
  parameter int unsigned IN_DEPTH  = 2,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  tba_pkg::item_t           item,
  output logic                     empty,
  input  logic                     pop,
  output tba_pkg::result_t         result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [tba_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]              cfg_data
);

  import tba_pkg::*;

  cfg_t    cfg;
  logic    in_empty;
  item_t   in_word;
  logic    in_pop;
  logic    out_full;
  logic    out_push;
  result_t out_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_time      <= StartTimeReset;
      cfg.bucket_length   <= BucketLengthReset;
      cfg.bucket_capacity <= BucketCapacityReset;
      cfg.raw_limit       <= RawLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_TIME:      cfg.start_time      <= cfg_data;
        REG_BUCKET_LENGTH:   cfg.bucket_length   <= cfg_data;
        REG_BUCKET_CAPACITY: cfg.bucket_capacity <= cfg_data[15:0];
        REG_RAW_LIMIT:       cfg.raw_limit       <= cfg_data[15:0];
        default:             cfg.start_time      <= cfg.start_time;
      endcase
    end
  end

  tba_fifo #(.word_t(item_t), .DEPTH(IN_DEPTH)) u_in_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata (item),
    .full  (full),
    .rd    (in_pop),
    .rdata (in_word),
    .empty (in_empty)
  );

  tba_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_empty (in_empty),
    .in_word  (in_word),
    .in_pop   (in_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_word (out_word)
  );

  tba_fifo #(.word_t(result_t), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (out_push),
    .wdata (out_word),
    .full  (out_full),
    .rd    (pop),
    .rdata (result),
    .empty (empty)
  );

`ifndef SYNTH
  a_push_room: assert property (@(posedge clk) disable iff (rst) out_push |-> !out_full)
    else $error("result pushed into full queue");
  a_pop_word: assert property (@(posedge clk) disable iff (rst) in_pop |-> !in_empty)
    else $error("record taken from empty queue");
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty && !full)
    else $error("queues not empty after reset");
`endif

endmodule

/* tb/tba_checker.sv */
// Bucket average checker: predicts bucket words from accepted records and compares them.
`timescale 1ns / 1ps
module tba_checker
  import tba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  item_t       item,
  input  logic        empty,
  input  logic        pop,
  input  result_t     result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  cfg_t cfg;
  logic passed_start, bucket_open;
  logic [15:0] raw_taken, buckets_sent, open_count;
  logic [31:0] open_time;
  logic signed [39:0] temp_sum;
  logic [31:0] hum_sum, eco2_sum, tvoc_sum;
  logic [23:0] air_sum;
  result_t bucket_q[$];

  function automatic void clear_bucket();
    bucket_open = 0; open_time = 0; open_count = 0; temp_sum = 0;
    hum_sum = 0; eco2_sum = 0; tvoc_sum = 0; air_sum = 0;
  endfunction

  function automatic void clear_run();
    passed_start = 0; raw_taken = 0; buckets_sent = 0;
    clear_bucket();
  endfunction

  function automatic void close_bucket(logic at_end);
    result_t r;
    logic signed [39:0] tm;
    if (!bucket_open || open_count == 0) return;
    tm = temp_sum / $signed({24'd0, open_count});
    buckets_sent = buckets_sent + 16'd1;
    r.bucket_time = open_time;
    r.sample_count = open_count;
    r.temp_mean = tm[15:0];
    r.humidity_mean = 16'(hum_sum / open_count);
    r.eco2_mean = 16'(eco2_sum / open_count);
    r.tvoc_mean = 16'(tvoc_sum / open_count);
    r.air_index_mean = 8'(air_sum / open_count);
    r.final_bucket = at_end || buckets_sent >= cfg.bucket_capacity;
    bucket_q.push_back(r);
    clear_bucket();
  endfunction

  function automatic void take_record(item_t it);
    logic enabled;
    logic [31:0] bt;
    enabled = cfg.bucket_length != 0 && cfg.bucket_capacity != 0;
    if (enabled && !passed_start && it.stamp >= cfg.start_time) passed_start = 1;
    if (enabled && passed_start && raw_taken < cfg.raw_limit &&
        buckets_sent < cfg.bucket_capacity) begin
      bt = (it.stamp / cfg.bucket_length) * cfg.bucket_length;
      if (bucket_open && bt != open_time) close_bucket(0);
      if (buckets_sent < cfg.bucket_capacity) begin
        if (!bucket_open) begin
          bucket_open = 1;
          open_time = bt;
        end
        open_count = open_count + 16'd1;
        temp_sum = temp_sum + 40'(it.temp_centi);
        hum_sum = hum_sum + it.humidity_centi;
        eco2_sum = eco2_sum + it.eco2_ppm;
        tvoc_sum = tvoc_sum + it.tvoc_ppb;
        air_sum = air_sum + it.air_index;
        raw_taken = raw_taken + 16'd1;
      end
    end
    if (it.end_of_stream) begin
      if (enabled && buckets_sent < cfg.bucket_capacity) close_bucket(1);
      clear_run();
    end
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      cfg = '{StartTimeReset, BucketLengthReset, BucketCapacityReset, RawLimitReset};
      clear_run();
      bucket_q.delete();
      fail_count = 0;
    end else begin
      if (pop && !empty) begin
        if (bucket_q.size() == 0) begin
          $error("unexpected bucket word, bucket_time %0h", result.bucket_time);
          fail_count++;
        end else begin
          e = bucket_q.pop_front();
          check_field("bucket_time", e.bucket_time, result.bucket_time);
          check_field("sample_count", e.sample_count, result.sample_count);
          check_field("temp_mean", 32'(e.temp_mean), 32'(result.temp_mean));
          check_field("humidity_mean", e.humidity_mean, result.humidity_mean);
          check_field("eco2_mean", e.eco2_mean, result.eco2_mean);
          check_field("tvoc_mean", e.tvoc_mean, result.tvoc_mean);
          check_field("air_index_mean", e.air_index_mean, result.air_index_mean);
          check_field("final_bucket", e.final_bucket, result.final_bucket);
        end
      end
      if (cfg_valid && cfg_ready)
        case (cfg_reg_t'(cfg_index))
          REG_START_TIME:      cfg.start_time = cfg_data;
          REG_BUCKET_LENGTH:   cfg.bucket_length = cfg_data;
          REG_BUCKET_CAPACITY: cfg.bucket_capacity = cfg_data[15:0];
          REG_RAW_LIMIT:       cfg.raw_limit = cfg_data[15:0];
          default: ;
        endcase
      if (push && !full) take_record(item);
    end
    pending = bucket_q.size();
  end

endmodule

/* tb/tb_top.sv */
// Testbench top: stimulus, register phases and verdict for the time bucket averager.
`timescale 1ns / 1ps
module tb_top;
  import tba_pkg::*;

  logic clk = 0, rst = 1;
  logic push = 0, pop = 0, cfg_valid = 0;
  logic full, empty, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  item_t item = '0;
  result_t result;
  int fail_count, pending;
  int cycles = 0;
  int stall_mode = 0;
  logic [31:0] run_stamp;

  time_bucket_averager dut (.*);

  tba_checker chk (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // receiver: stall pattern changes per phase
  always @(negedge clk) begin
    case (stall_mode)
      0: pop <= 1;
      1: pop <= ($urandom_range(3) != 0);
      default: pop <= ($urandom_range(9) == 0);
    endcase
  end

  task automatic send_word(item_t w);
    item <= w;
    push <= 1;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic gap();
    push <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic drain();
    push <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  function automatic item_t rand_word(logic [31:0] st, logic eos);
    item_t w;
    w.stamp = st;
    w.temp_centi = 16'($urandom);
    w.humidity_centi = 16'($urandom);
    w.eco2_ppm = 16'($urandom);
    w.tvoc_ppb = 16'($urandom);
    w.air_index = 8'($urandom);
    w.end_of_stream = eos;
    return w;
  endfunction

  // one run: mostly rising stamps with occasional random jumps, mostly a few words per bucket
  task automatic run_stream(int n, logic [31:0] base, int stride);
    item_t w;
    run_stamp = base;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) run_stamp = $urandom;
      else run_stamp = run_stamp + $urandom_range(stride);
      w = rand_word(run_stamp, i == n - 1);
      send_word(w);
      if ($urandom_range(3) == 0) gap();
    end
  endtask

  initial begin
    item_t w;
    int sent;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: extremes and sign handling with default registers
    stall_mode = 0;
    w = '0; send_word(w);
    w = '1; w.end_of_stream = 0; w.stamp = 32'd30; w.temp_centi = -16'sd32768;
    send_word(w);
    w.stamp = 32'd59; w.temp_centi = 16'sd1; send_word(w);
    w = '1; w.stamp = 32'd60; w.temp_centi = 16'sd32767; w.end_of_stream = 0;
    send_word(w);
    w.temp_centi = -16'sd2; send_word(w);
    w.stamp = 32'hFFFF_FFFF; w.end_of_stream = 1; send_word(w);
    w = '0; w.end_of_stream = 1; send_word(w);
    w.stamp = 32'd5; send_word(w);
    w = '0; w.stamp = 32'd200; send_word(w);
    w.stamp = 32'd100; w.temp_centi = -16'sd7; send_word(w);
    w.end_of_stream = 1; send_word(w);
    drain();

    // skip threshold, raw limit, capacity reached
    write_reg(REG_START_TIME, 32'd1000);
    write_reg(REG_RAW_LIMIT, 32'd3);
    write_reg(REG_BUCKET_CAPACITY, 32'd2);
    write_reg(REG_BUCKET_LENGTH, 32'd10);
    stall_mode = 1;
    for (int i = 0; i < 8; i++) begin
      w = rand_word(32'd995 + 3 * i, i == 7);
      send_word(w);
    end
    drain();
    write_reg(REG_RAW_LIMIT, 32'd65535);
    for (int i = 0; i < 6; i++) send_word(rand_word(32'd1000 + 10 * i, i == 5));
    drain();

    // disabled settings
    write_reg(REG_BUCKET_LENGTH, 32'd0);
    for (int i = 0; i < 3; i++) send_word(rand_word(32'd2000 + i, i == 2));
    drain();
    write_reg(REG_BUCKET_LENGTH, 32'd60);
    write_reg(REG_BUCKET_CAPACITY, 32'd0);
    for (int i = 0; i < 3; i++) send_word(rand_word(32'd2000 + i, i == 2));
    drain();

    // random phases over several register settings
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = ph % 3;
      case (ph)
        0: begin write_reg(REG_START_TIME, 0); write_reg(REG_BUCKET_LENGTH, 5);
                 write_reg(REG_BUCKET_CAPACITY, 64); write_reg(REG_RAW_LIMIT, 2000); end
        1: begin write_reg(REG_BUCKET_LENGTH, 32'hFFFF_FFFF);
                 write_reg(REG_BUCKET_CAPACITY, 65535); write_reg(REG_RAW_LIMIT, 65535); end
        2: begin write_reg(REG_BUCKET_LENGTH, 1); write_reg(REG_BUCKET_CAPACITY, 5);
                 write_reg(REG_RAW_LIMIT, 1); end
        3: begin write_reg(REG_START_TIME, 32'hFFFF_FFFF); write_reg(REG_RAW_LIMIT, 40);
                 write_reg(REG_BUCKET_CAPACITY, 10); write_reg(REG_BUCKET_LENGTH, 3); end
        4: begin write_reg(REG_START_TIME, 32'h8000_0000); write_reg(REG_BUCKET_LENGTH, 7);
                 write_reg(REG_BUCKET_CAPACITY, 1); end
        default: begin write_reg(REG_START_TIME, 0); write_reg(REG_BUCKET_LENGTH, 60);
                 write_reg(REG_BUCKET_CAPACITY, 64); write_reg(REG_RAW_LIMIT, 2000); end
      endcase
      for (int r = 0; r < 10; r++) begin
        run_stream($urandom_range(4, 20),
                   (ph == 4) ? 32'h7FFF_FFF0 + $urandom_range(40) : $urandom,
                   (ph == 2) ? 2 : 12);
        sent += 10;
        if ($urandom_range(3) == 0) gap();
      end
      drain();
    end

    stall_mode = 0;
    drain();
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
